// ----- sv/rbsi_pkg.sv -----
// Shared types and constants for the ray versus box slab test.
package rbsi_pkg;

  localparam int unsigned DIV_LAT   = 34;
  localparam int unsigned MERGE_LAT = 2;
  localparam int unsigned TOTAL_LAT = DIV_LAT + MERGE_LAT;

  localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] EXIT_SMALL = 32'sd66;
  localparam logic signed [31:0] NEAR_LIMIT = 32'sd6554;

  localparam logic [2:0] REG_CORNER_A_X = 3'd0;
  localparam logic [2:0] REG_CORNER_A_Y = 3'd1;
  localparam logic [2:0] REG_CORNER_A_Z = 3'd2;
  localparam logic [2:0] REG_CORNER_B_X = 3'd3;
  localparam logic [2:0] REG_CORNER_B_Y = 3'd4;
  localparam logic [2:0] REG_CORNER_B_Z = 3'd5;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } span_t;

  typedef struct packed {
    logic zero;
    logic in_slab;
  } zflag_t;

endpackage

// ----- sv/rbsi_div.sv -----
// Pipelined signed divider: saturated (diff * 65536) / den, one quotient bit per stage.
module rbsi_div (
  input  logic               clk,
  input  logic signed [32:0] diff,
  input  logic signed [31:0] den,
  output logic signed [31:0] quot
);

  logic [32:0] diff_mag;
  logic [31:0] den_mag;
  logic [48:0] num;
  logic        ovf;

  logic [31:0] rem_q [0:32];
  logic [31:0] low_q [0:32];
  logic [31:0] quo_q [0:32];
  logic [31:0] den_q [0:32];
  logic        neg_q [0:32];
  logic        ovf_q [0:32];

  always_comb begin
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    den_mag  = den[31] ? 32'(-den) : 32'(den);
    num      = {diff_mag, 16'b0};
    ovf      = {15'b0, num[48:32]} >= den_mag;
  end

  always_ff @(posedge clk) begin
    rem_q[0] <= {15'b0, num[48:32]};
    low_q[0] <= num[31:0];
    quo_q[0] <= '0;
    den_q[0] <= den_mag;
    neg_q[0] <= diff[32] ^ den[31];
    ovf_q[0] <= ovf;
  end

  for (genvar i = 0; i < 32; i++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] sub;
    logic        ge;
    assign trial = {rem_q[i], low_q[i][31]};
    assign sub   = trial - {1'b0, den_q[i]};
    assign ge    = trial >= {1'b0, den_q[i]};
    always_ff @(posedge clk) begin
      rem_q[i+1] <= ge ? sub[31:0] : trial[31:0];
      low_q[i+1] <= {low_q[i][30:0], 1'b0};
      quo_q[i+1] <= {quo_q[i][30:0], ge};
      den_q[i+1] <= den_q[i];
      neg_q[i+1] <= neg_q[i];
      ovf_q[i+1] <= ovf_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf_q[32]) begin
      quot <= neg_q[32] ? rbsi_pkg::Q_MIN : rbsi_pkg::Q_MAX;
    end else if (!neg_q[32]) begin
      quot <= quo_q[32][31] ? rbsi_pkg::Q_MAX : $signed(quo_q[32]);
    end else if (quo_q[32] > 32'h8000_0000) begin
      quot <= rbsi_pkg::Q_MIN;
    end else begin
      quot <= $signed(32'(-quo_q[32]));
    end
  end

endmodule

// ----- sv/rbsi_axis_lane.sv -----
// One axis lane: near and far slab distances with the zero direction rule.
module rbsi_axis_lane (
  input  logic                  clk,
  input  logic signed [31:0]    corner_a,
  input  logic signed [31:0]    corner_b,
  input  logic signed [31:0]    org,
  input  logic signed [31:0]    dir,
  output rbsi_pkg::span_t       span
);

  logic signed [32:0] diff_lo;
  logic signed [32:0] diff_hi;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;
  logic signed [31:0] mn;
  logic signed [31:0] mx;
  rbsi_pkg::zflag_t   zin;
  rbsi_pkg::zflag_t   zline [0:rbsi_pkg::DIV_LAT-1];

  always_comb begin
    if (dir < 0) begin
      diff_lo = 33'(corner_b) - 33'(org);
      diff_hi = 33'(corner_a) - 33'(org);
    end else begin
      diff_lo = 33'(corner_a) - 33'(org);
      diff_hi = 33'(corner_b) - 33'(org);
    end
    mn          = (corner_a < corner_b) ? corner_a : corner_b;
    mx          = (corner_a < corner_b) ? corner_b : corner_a;
    zin.zero    = dir == 0;
    zin.in_slab = !(org < mn || org > mx);
  end

  rbsi_div u_div_lo (.clk(clk), .diff(diff_lo), .den(dir), .quot(lo_q));
  rbsi_div u_div_hi (.clk(clk), .diff(diff_hi), .den(dir), .quot(hi_q));

  always_ff @(posedge clk) begin
    zline[0] <= zin;
    for (int i = 1; i < rbsi_pkg::DIV_LAT; i++) begin
      zline[i] <= zline[i-1];
    end
  end

  always_comb begin
    span.ok = !zline[rbsi_pkg::DIV_LAT-1].zero || zline[rbsi_pkg::DIV_LAT-1].in_slab;
    span.lo = zline[rbsi_pkg::DIV_LAT-1].zero ? rbsi_pkg::Q_MIN : lo_q;
    span.hi = zline[rbsi_pkg::DIV_LAT-1].zero ? rbsi_pkg::Q_MAX : hi_q;
  end

endmodule

// ----- sv/rbsi_merge.sv -----
// Merges the three axis spans into one interval and picks the hit distance.
module rbsi_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  rbsi_pkg::span_t [2:0]       spans,
  input  logic signed [31:0]          cur,
  output logic                        done,
  output logic                        hit,
  output logic signed [31:0]          nearest_now
);

  logic               ok_c;
  logic signed [31:0] tmin_c;
  logic signed [31:0] tmax_c;
  logic               a_valid;
  logic               a_ok;
  logic signed [31:0] a_tmin;
  logic signed [31:0] a_tmax;
  logic signed [31:0] a_cur;
  logic               take_min;
  logic               take_max;

  always_comb begin
    ok_c   = spans[0].ok;
    tmin_c = spans[0].lo;
    tmax_c = spans[0].hi;
    for (int k = 1; k < 3; k++) begin
      if (!spans[k].ok || tmin_c > spans[k].hi || spans[k].lo > tmax_c) begin
        ok_c = 1'b0;
      end else begin
        if (spans[k].lo > tmin_c) tmin_c = spans[k].lo;
        if (spans[k].hi < tmax_c) tmax_c = spans[k].hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= valid;
    end
    a_ok   <= ok_c;
    a_tmin <= tmin_c;
    a_tmax <= tmax_c;
    a_cur  <= cur;
  end

  always_comb begin
    take_min = (a_tmin < a_tmax || a_tmax < rbsi_pkg::EXIT_SMALL)
               && a_tmin > rbsi_pkg::NEAR_LIMIT && a_tmin < a_cur;
    take_max = (a_tmax < a_tmin || a_tmin < rbsi_pkg::EXIT_SMALL)
               && a_tmax > rbsi_pkg::NEAR_LIMIT && a_tmax < a_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= a_valid;
      hit  <= a_valid && a_ok && (take_min || take_max);
    end
    if (a_ok && take_min) begin
      nearest_now <= a_tmin;
    end else if (a_ok && take_max) begin
      nearest_now <= a_tmax;
    end else begin
      nearest_now <= a_cur;
    end
  end

endmodule

// ----- sv/ray_box_slab_intersect_core.sv -----
// Top level of the ray versus axis-aligned box slab test.
// A ray is taken on every cycle that start is high and busy is low; busy is high only
// during reset. Each ray gives one word on done, hit and nearest_now, registered through
// the 32-stage restoring divider in each of the three axis lanes plus setup, saturation
// and two merge stages. The result is shown for one cycle only and must be captured
// then. Corners are written through cfg_we, cfg_index and cfg_data and should change
// only while no ray is in flight.
module ray_box_slab_intersect_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] direction_x,
  input  logic signed [31:0] direction_y,
  input  logic signed [31:0] direction_z,
  input  logic signed [31:0] nearest_so_far,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] nearest_now
);

  logic signed [31:0]     corner_a [0:2];
  logic signed [31:0]     corner_b [0:2];
  logic signed [31:0]     org_v    [0:2];
  logic signed [31:0]     dir_v    [0:2];
  logic                   valid_line [0:rbsi_pkg::DIV_LAT-1];
  logic signed [31:0]     cur_line   [0:rbsi_pkg::DIV_LAT-1];
  rbsi_pkg::span_t [2:0]  spans;
  logic                   accept;

  assign busy   = rst;
  assign accept = start && !busy;

  assign org_v[0] = origin_x;
  assign org_v[1] = origin_y;
  assign org_v[2] = origin_z;
  assign dir_v[0] = direction_x;
  assign dir_v[1] = direction_y;
  assign dir_v[2] = direction_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a[0] <= 32'sd0;
      corner_a[1] <= -32'sd65536;
      corner_a[2] <= 32'sd0;
      corner_b[0] <= 32'sd0;
      corner_b[1] <= 32'sd0;
      corner_b[2] <= 32'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbsi_pkg::REG_CORNER_A_X: corner_a[0] <= $signed(cfg_data);
        rbsi_pkg::REG_CORNER_A_Y: corner_a[1] <= $signed(cfg_data);
        rbsi_pkg::REG_CORNER_A_Z: corner_a[2] <= $signed(cfg_data);
        rbsi_pkg::REG_CORNER_B_X: corner_b[0] <= $signed(cfg_data);
        rbsi_pkg::REG_CORNER_B_Y: corner_b[1] <= $signed(cfg_data);
        rbsi_pkg::REG_CORNER_B_Z: corner_b[2] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rbsi_pkg::DIV_LAT; i++) begin
        valid_line[i] <= 1'b0;
      end
    end else begin
      valid_line[0] <= accept;
      for (int i = 1; i < rbsi_pkg::DIV_LAT; i++) begin
        valid_line[i] <= valid_line[i-1];
      end
    end
    cur_line[0] <= nearest_so_far;
    for (int i = 1; i < rbsi_pkg::DIV_LAT; i++) begin
      cur_line[i] <= cur_line[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rbsi_axis_lane u_lane (
      .clk      (clk),
      .corner_a (corner_a[k]),
      .corner_b (corner_b[k]),
      .org      (org_v[k]),
      .dir      (dir_v[k]),
      .span     (spans[k])
    );
  end

  rbsi_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .valid       (valid_line[rbsi_pkg::DIV_LAT-1]),
    .spans       (spans),
    .cur         (cur_line[rbsi_pkg::DIV_LAT-1]),
    .done        (done),
    .hit         (hit),
    .nearest_now (nearest_now)
  );

endmodule

// ----- sv/rbsi_checker.sv -----
// Port-level checks for the slab test core and their binding.
module rbsi_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] nearest_so_far,
  input logic               done,
  input logic               hit,
  input logic signed [31:0] nearest_now
);

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rbsi_pkg::TOTAL_LAT))
    else $error("Result word without a matching accepted word.");

  a_hit_only_with_done: assert property (@(posedge clk) disable iff (rst)
    hit |-> done)
    else $error("Hit raised outside a result word.");

  a_miss_keeps_distance: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> nearest_now == $past(nearest_so_far, rbsi_pkg::TOTAL_LAT))
    else $error("Miss changed the nearest distance.");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit |-> (nearest_now > rbsi_pkg::NEAR_LIMIT
             && nearest_now < $past(nearest_so_far, rbsi_pkg::TOTAL_LAT)))
    else $error("Hit distance outside the allowed range.");

endmodule

bind ray_box_slab_intersect_core rbsi_checker u_rbsi_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .nearest_so_far (nearest_so_far),
  .done           (done),
  .hit            (hit),
  .nearest_now    (nearest_now)
);
